// File: rtl/pdrs_pkg.sv
// Shared types and constants for the PWM divider and resolution solver.
package pdrs_pkg;

  localparam int unsigned TARGET_W   = 32;
  localparam int unsigned DUTY_W     = 32;
  localparam int unsigned CRYSTAL_W  = 31;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned DIVIDER_W  = 18;
  localparam int unsigned BITS_W     = 4;
  localparam int unsigned COUNT_W    = 15;
  // duty is at most one (65536) once checked, so 17 bits hold it
  localparam int unsigned DUTY_CHK_W = 17;
  localparam int unsigned DUTY_SHIFT = 16;

  localparam logic [CRYSTAL_W-1:0]  CRYSTAL_RESET = 31'd40000000;
  localparam logic [DUTY_W-1:0]     DUTY_ONE      = 32'd65536;
  localparam logic [DIVIDER_W:0]    DIVIDER_MIN   = 19'd256;
  localparam logic [DIVIDER_W:0]    DIVIDER_MAX   = 19'h3ffff;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

  localparam logic REG_CRYSTAL = 1'b0;
  localparam logic REG_READY   = 1'b1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/pwm_divider_resolution_solver_core.sv
// Top level of the PWM clock divider and duty resolution solver.
//
// Each request transfer carries a target frequency and a 16.16 duty
// fraction. Requests with zero frequency, duty above one or a zero crystal
// setting are answered at once with invalid-argument status. Otherwise the
// sequencer walks the counter resolution down from MAX_RESOLUTION to 1 and,
// for each, runs one rounded division crystal*2^FRACTION_BITS / (freq << res)
// on a single shared restoring divider that yields one quotient bit a cycle.
// The first divider that lands in 256..262143 wins; the duty count is then
// rounded at that resolution. Status precedence: invalid, no fit, not ready.
// Rate: one request at a time. Each request runs one division per
// resolution tried (1..MAX_RESOLUTION), on a dividend DVD_W bits wide
// (46 with default parameters). The result sits in an output register,
// so a new request is taken while the previous result still waits.
// Configuration writes (crystal_hz index 0, channel_ready index 1) must only
// be made while no request is in progress.
module pwm_divider_resolution_solver_core #(
  parameter int unsigned FRACTION_BITS  = 8,
  parameter int unsigned MAX_RESOLUTION = 14
) (
  input  logic        clk,
  input  logic        rst,
  // request: [31:0] target_hz, [63:32] duty_fraction
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  // result: [1:0] status, [19:2] clock_divider, [23:20] duty_bits,
  // [38:24] duty_count, [39] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam int unsigned NUM_W   = pdrs_pkg::CRYSTAL_W + FRACTION_BITS;
  localparam int unsigned DEN_W   = pdrs_pkg::TARGET_W + MAX_RESOLUTION;
  localparam int unsigned DVD_W   = ((NUM_W > DEN_W - 1) ? NUM_W : DEN_W - 1) + 1;
  localparam int unsigned RES_W   = $clog2(MAX_RESOLUTION + 1);
  localparam int unsigned DMUL_W  = pdrs_pkg::DUTY_CHK_W + MAX_RESOLUTION + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  // configuration registers
  logic [pdrs_pkg::CRYSTAL_W-1:0] crystal_hz;
  logic                           channel_ready;

  // request under work
  logic [pdrs_pkg::TARGET_W-1:0]   freq;
  logic [pdrs_pkg::DUTY_CHK_W-1:0] duty;
  logic [RES_W-1:0]                res;

  // pending result
  logic [pdrs_pkg::STATUS_W-1:0]  rs_status;
  logic [pdrs_pkg::DIVIDER_W-1:0] rs_divider;
  logic [pdrs_pkg::BITS_W-1:0]    rs_bits;
  logic [pdrs_pkg::COUNT_W-1:0]   rs_count;

  // output register
  logic [pdrs_pkg::STATUS_W-1:0]  o_status;
  logic [pdrs_pkg::DIVIDER_W-1:0] o_divider;
  logic [pdrs_pkg::BITS_W-1:0]    o_bits;
  logic [pdrs_pkg::COUNT_W-1:0]   o_count;

  logic                 in_xfer;
  logic                 req_invalid;
  logic [DEN_W-1:0]     denom;
  logic [DVD_W-1:0]     dividend;
  logic [DVD_W-1:0]     quotient;
  logic                 fits;
  logic [DMUL_W-1:0]    duty_scaled;
  logic                 out_free;
  pdrs_pkg::div_stat_t  div_stat;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign req_invalid = (s_tdata[31:0] == '0) ||
                       (s_tdata[63:32] > pdrs_pkg::DUTY_ONE) ||
                       (crystal_hz == '0);

  // rounded divider: (numer + denom/2) / denom
  assign denom    = DEN_W'(freq) << res;
  assign dividend = (DVD_W'(crystal_hz) << FRACTION_BITS) + DVD_W'(denom >> 1);

  assign fits = (quotient >= DVD_W'(pdrs_pkg::DIVIDER_MIN)) &&
                (quotient <= DVD_W'(pdrs_pkg::DIVIDER_MAX));

  // duty * 2^res + half, then drop 16 fraction bits
  assign duty_scaled = (DMUL_W'(duty) << res) + DMUL_W'(32768);

  pdrs_div #(
    .DVD_W (DVD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (dividend),
    .divisor  (denom),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz    <= pdrs_pkg::CRYSTAL_RESET;
      channel_ready <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pdrs_pkg::REG_CRYSTAL: crystal_hz    <= cfg_wdata;
        pdrs_pkg::REG_READY:   channel_ready <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= req_invalid ? S_FINISH : S_START;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (div_stat.done) begin
            if (fits || res == RES_W'(1)) begin
              state <= S_FINISH;
            end else begin
              state <= S_START;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      freq       <= s_tdata[31:0];
      duty       <= s_tdata[32 +: pdrs_pkg::DUTY_CHK_W];
      res        <= RES_W'(MAX_RESOLUTION);
      rs_status  <= pdrs_pkg::ST_INVALID;
      rs_divider <= '0;
      rs_bits    <= '0;
      rs_count   <= '0;
    end else if (state == S_WAIT && div_stat.done) begin
      if (fits) begin
        if (channel_ready) begin
          rs_status  <= pdrs_pkg::ST_OK;
          rs_divider <= pdrs_pkg::DIVIDER_W'(quotient);
          rs_bits    <= pdrs_pkg::BITS_W'(res);
          rs_count   <= pdrs_pkg::COUNT_W'(duty_scaled >> pdrs_pkg::DUTY_SHIFT);
        end else begin
          rs_status  <= pdrs_pkg::ST_NOT_READY;
        end
      end else if (res == RES_W'(1)) begin
        rs_status <= pdrs_pkg::ST_NO_FIT;
      end else begin
        res <= res - RES_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      o_status  <= rs_status;
      o_divider <= rs_divider;
      o_bits    <= rs_bits;
      o_count   <= rs_count;
    end
  end

  assign m_tdata = {1'b0, o_count, o_bits, o_divider, o_status};

endmodule

// File: rtl/pdrs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module pdrs_div #(
  parameter int unsigned DVD_W = 46,
  parameter int unsigned DEN_W = 46
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DEN_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output pdrs_pkg::div_stat_t  stat
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DVD_W-1:0] dq;       // dividend shifts out at the top, quotient in at the bottom
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           ge;

  assign shifted = {rem, dq[DVD_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dq  <= {dq[DVD_W-2:0], ge};
    end
  end

  assign quotient = dq;
  assign stat     = pdrs_pkg::div_stat_t'{busy: busy, done: done};

endmodule
